[hdl/adaptive_grid_rebin_defines.svh]
// Assertion macros shared by the adaptive grid rebin RTL.
// No dependencies.
`ifndef ADAPTIVE_GRID_REBIN_DEFINES_SVH
`define ADAPTIVE_GRID_REBIN_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define AGR_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define AGR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

[hdl/agr_pkg.sv]
// Shared constants and types for the adaptive grid rebin block.
// No dependencies.
`default_nettype none
package agr_pkg;
   localparam int MaxBins  = 512;
   localparam int AddrW    = $clog2(MaxBins);
   localparam logic [31:0] EdgeOne = 32'h8000_0000;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EMIT  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_CLAMP = 2'd1,
      ST_ZDIV  = 2'd2
   } status_type;

   // divider handshake
   typedef struct packed {
      logic        go;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

[hdl/agr_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module agr_ram #(
   parameter int Width = 32,
   parameter int Depth = 512
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  addr,
   input  wire [Width-1:0]          wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[hdl/agr_div.sv]
// Restoring divider, one quotient bit a cycle (64 by 32, quotient fits 32 bits).
// Depends on agr_pkg and the assertion macros.
`default_nettype none
`include "adaptive_grid_rebin_defines.svh"
module agr_div
   import agr_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [63:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, 1'b0} - {1'b0, dvs_ff, 32'd0};
      if (req.go) begin
         rem_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // quotient < 2^32 since dividend < divisor * 2^32
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], 1'b0};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   `AGR_ASSERT_NEXT(a_done_one, clock, reset, done_ff, !done_ff)
   `AGR_ASSERT_IMP(a_no_restart, clock, reset, busy_ff, !req.go)
   `AGR_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)
endmodule
`default_nettype wire

[hdl/adaptive_grid_rebin.sv]
// Adaptive grid rebin: sequencer, bin stores and walk state.
// Depends on agr_pkg, agr_ram, agr_div and the assertion macros.
//
// Usage: an item is taken when start is high and busy low. Load items
// write one bin weight and old edge (bin index 1 to 512); start items set
// the target weight and clear the walk; emit items, until the grid's last
// edge is out, produce one new edge on rsp_* with rsp_valid high for one
// cycle. An emit walks the stored bins one at a time through the single RAM
// port, then, for a nonzero bin weight and no clamp, runs a bit-serial
// 32-step divide. The final edge needs no walk or divide. The weight and
// edge memories are single ported. Reset clears the walk and sets
// bins_in_use to 500; memory contents are undefined until loaded. The
// receiver cannot stall: each result is shown for exactly one cycle.
// csr_wr_en writes bins_in_use; the user must use it only while busy is
// low, as the block itself does not enforce this.
`default_nettype none
`include "adaptive_grid_rebin_defines.svh"
module adaptive_grid_rebin
   import agr_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_opcode,
   input  wire  [9:0]  req_bin_index,
   input  wire  [31:0] req_bin_weight,
   input  wire  [31:0] req_old_edge,
   input  wire  [31:0] req_target_weight,
   input  wire         csr_wr_en,
   input  wire  [9:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_new_edge,
   output logic [9:0]  rsp_edge_number,
   output logic        rsp_last_edge,
   output logic [1:0]  rsp_status
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_CHECK, S_RDW, S_ACC, S_RDLO, S_LO,
      S_RDHI, S_HI, S_DIV, S_WAIT, S_DONE
   } state_type;

   state_type     state_ff;
   logic [9:0]    nd_ff;
   logic [9:0]    walk_ff;
   logic [47:0]   cum_ff;
   logic [31:0]   lower_ff;
   logic [9:0]    emit_ff;
   logic [31:0]   target_ff;
   logic [31:0]   xn_ff, w_ff;
   logic [1:0]    stat_ff;
   logic          up_ff;
   logic [AddrW-1:0] addr_ff;
   logic          we_ff;
   logic [31:0]   wdat_w_ff, wdat_e_ff;
   logic [31:0]   rd_w, rd_e;
   div_req_type   dreq;
   div_rsp_type   drsp;
   logic [9:0]    nd_sat;
   logic [31:0]   mag;
   logic [47:0]   rest;
   logic [47:0]   cum_sum;

   assign nd_sat = (nd_ff < 10'd2) ? 10'd2 :
                   ({1'b0, nd_ff} > 11'(MaxBins)) ? 10'(MaxBins) : nd_ff;

   agr_ram #(.Width(32), .Depth(MaxBins)) u_wram (
      .clock(clock), .wr_en(we_ff), .addr(addr_ff), .wr_data(wdat_w_ff), .rd_data(rd_w));
   agr_ram #(.Width(32), .Depth(MaxBins)) u_eram (
      .clock(clock), .wr_en(we_ff), .addr(addr_ff), .wr_data(wdat_e_ff), .rd_data(rd_e));

   agr_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign cum_sum = cum_ff + {16'd0, rd_w};
   assign mag     = (xn_ff >= lower_ff) ? xn_ff - lower_ff : lower_ff - xn_ff;
   assign rest    = (cum_ff > {16'd0, w_ff}) ? {16'd0, w_ff} : cum_ff;

   // rest is clamped to the bin weight, so 32 x 32 bits suffice
   always_comb begin
      dreq.go       = (state_ff == S_DIV);
      dreq.dividend = {32'd0, mag} * {32'd0, rest[31:0]};
      dreq.divisor  = w_ff;
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         nd_ff     <= 10'd500;
         walk_ff   <= '0;
         cum_ff    <= '0;
         lower_ff  <= '0;
         emit_ff   <= '0;
         target_ff <= '0;
         we_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         we_ff     <= 1'b0;
         rsp_valid <= 1'b0;
         if (csr_wr_en) begin
            nd_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  unique case (opcode_type'(req_opcode))
                     OP_LOAD: begin
                        if (req_bin_index != 10'd0 &&
                            {1'b0, req_bin_index} <= 11'(MaxBins)) begin
                           we_ff <= 1'b1;
                        end
                        addr_ff   <= AddrW'(req_bin_index - 10'd1);
                        wdat_w_ff <= req_bin_weight;
                        wdat_e_ff <= req_old_edge;
                        state_ff  <= S_LOAD;
                     end
                     OP_START: begin
                        target_ff <= req_target_weight;
                        walk_ff   <= '0;
                        cum_ff    <= '0;
                        lower_ff  <= '0;
                        emit_ff   <= '0;
                        state_ff  <= S_LOAD;
                     end
                     OP_EMIT: begin
                        if (emit_ff >= nd_sat) begin
                           state_ff <= S_LOAD;
                        end else begin
                           emit_ff <= emit_ff + 10'd1;
                           stat_ff <= ST_OK;
                           if (emit_ff + 10'd1 == nd_sat) begin
                              rsp_valid       <= 1'b1;
                              rsp_new_edge    <= EdgeOne;
                              rsp_edge_number <= emit_ff + 10'd1;
                              rsp_last_edge   <= 1'b1;
                              rsp_status      <= ST_OK;
                              state_ff        <= S_LOAD;
                           end else begin
                              state_ff <= S_CHECK;
                           end
                        end
                     end
                     default: state_ff <= S_LOAD;
                  endcase
               end
            end
            S_LOAD: state_ff <= S_IDLE;
            S_CHECK: begin
               if ({16'd0, target_ff} > cum_ff) begin
                  if (walk_ff >= nd_sat) begin
                     stat_ff  <= ST_CLAMP;
                     cum_ff   <= '0;
                     state_ff <= S_RDLO;
                  end else begin
                     addr_ff  <= AddrW'(walk_ff);
                     walk_ff  <= walk_ff + 10'd1;
                     state_ff <= S_RDW;
                  end
               end else begin
                  cum_ff   <= cum_ff - {16'd0, target_ff};
                  state_ff <= S_RDLO;
               end
            end
            S_RDW: state_ff <= S_ACC;
            S_ACC: begin
               cum_ff   <= cum_sum;
               state_ff <= S_CHECK;
            end
            S_RDLO: begin
               if (walk_ff == 10'd0) begin
                  rsp_valid       <= 1'b1;
                  rsp_new_edge    <= '0;
                  rsp_edge_number <= emit_ff;
                  rsp_last_edge   <= 1'b0;
                  rsp_status      <= stat_ff;
                  state_ff        <= S_LOAD;
               end else begin
                  addr_ff  <= AddrW'(walk_ff - 10'd2);
                  state_ff <= S_LO;
               end
            end
            S_LO: begin
               addr_ff  <= AddrW'(walk_ff - 10'd1);
               state_ff <= S_RDHI;
            end
            // lower edge read data lands here, in the cycle after its address reaches the RAM
            S_RDHI: begin
               if (walk_ff > 10'd1) begin
                  lower_ff <= rd_e;
               end
               state_ff <= S_HI;
            end
            S_HI: begin
               xn_ff <= rd_e;
               w_ff  <= rd_w;
               if (stat_ff == ST_CLAMP || rd_w == 32'd0) begin
                  rsp_valid       <= 1'b1;
                  rsp_new_edge    <= rd_e;
                  rsp_edge_number <= emit_ff;
                  rsp_last_edge   <= 1'b0;
                  rsp_status      <= (stat_ff == ST_CLAMP) ? ST_CLAMP : ST_ZDIV;
                  state_ff        <= S_LOAD;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               up_ff    <= (xn_ff >= lower_ff);
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (drsp.done) begin
                  rsp_valid       <= 1'b1;
                  rsp_new_edge    <= up_ff ? xn_ff - drsp.quotient
                                           : xn_ff + drsp.quotient;
                  rsp_edge_number <= emit_ff;
                  rsp_last_edge   <= 1'b0;
                  rsp_status      <= ST_OK;
                  state_ff        <= S_LOAD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `AGR_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `AGR_ASSERT_IMP(a_walk_bound, clock, reset, 1'b1, walk_ff <= 10'(MaxBins))
   `AGR_ASSERT_IMP(a_last_one, clock, reset, rsp_valid && rsp_last_edge,
                   rsp_new_edge == EdgeOne)
endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for adaptive_grid_rebin: directed and random load, start and emit items.
// Depends on agr_pkg and the adaptive_grid_rebin RTL.
`default_nettype none

import agr_pkg::*;

class rebin_scoreboard;
   typedef struct {
      logic [31:0] new_edge;
      logic [9:0]  edge_number;
      logic        last_edge;
      status_type  status;
   } edge_result_type;

   logic [31:0]     weight_mem [MaxBins];
   logic [31:0]     edge_mem [MaxBins];
   int unsigned     walk_bin;
   logic [47:0]     running_sum;
   logic [31:0]     prev_edge;
   int unsigned     edges_done;
   logic [31:0]     share;
   logic [9:0]      bins_reg;
   edge_result_type edge_queue [$];
   int              fails;

   function new();
      walk_bin    = 0;
      running_sum = '0;
      prev_edge   = '0;
      edges_done  = 0;
      share       = '0;
      bins_reg    = 10'd500;
      fails       = 0;
      foreach (weight_mem[k]) begin
         weight_mem[k] = '0;
         edge_mem[k]   = '0;
      end
   endfunction

   function int unsigned grid_size();
      if (bins_reg < 2) return 2;
      if (bins_reg > MaxBins) return MaxBins;
      return bins_reg;
   endfunction

   function void write_bins(logic [9:0] value);
      bins_reg = value;
   endfunction

   function void accept_item(opcode_type op, logic [9:0] idx, logic [31:0] wt,
                             logic [31:0] old_e, logic [31:0] tgt);
      edge_result_type r;
      int unsigned     nd;
      logic [31:0]     xn, w, xo;
      logic [63:0]     mag, rest, q;
      nd = grid_size();
      case (op)
         OP_LOAD: begin
            if (idx >= 1 && idx <= MaxBins) begin
               weight_mem[idx - 1] = wt;
               edge_mem[idx - 1]   = old_e;
            end
         end
         OP_START: begin
            share       = tgt;
            walk_bin    = 0;
            running_sum = '0;
            prev_edge   = '0;
            edges_done  = 0;
         end
         OP_EMIT: begin
            if (edges_done < nd) begin
               edges_done++;
               r.edge_number = edges_done[9:0];
               r.last_edge   = 1'b0;
               r.status      = ST_OK;
               if (edges_done == nd) begin
                  r.new_edge  = EdgeOne;
                  r.last_edge = 1'b1;
               end else begin
                  while ({16'd0, share} > running_sum) begin
                     if (walk_bin >= nd) begin
                        r.status = ST_CLAMP;
                        break;
                     end
                     walk_bin++;
                     running_sum = running_sum + {16'd0, weight_mem[walk_bin - 1]};
                  end
                  if (r.status == ST_CLAMP) running_sum = '0;
                  else running_sum = running_sum - {16'd0, share};
                  if (walk_bin == 0) begin
                     r.new_edge = '0;
                  end else begin
                     if (walk_bin > 1) prev_edge = edge_mem[walk_bin - 2];
                     xn = edge_mem[walk_bin - 1];
                     w  = weight_mem[walk_bin - 1];
                     if (r.status == ST_CLAMP) begin
                        r.new_edge = xn;
                     end else if (w == 0) begin
                        r.status   = ST_ZDIV;
                        r.new_edge = xn;
                     end else begin
                        xo   = prev_edge;
                        mag  = (xn >= xo) ? {32'd0, xn - xo} : {32'd0, xo - xn};
                        rest = {16'd0, running_sum};
                        if (rest > {32'd0, w}) rest = {32'd0, w};
                        q = (mag * rest) / {32'd0, w};
                        r.new_edge = (xn >= xo) ? xn - q[31:0] : xn + q[31:0];
                     end
                  end
               end
               edge_queue.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function void check_edge(logic [31:0] new_edge, logic [9:0] num, logic last,
                            logic [1:0] st);
      edge_result_type r;
      if (edge_queue.size() == 0) begin
         $display("%0t: unexpected edge %h number %0d", $time, new_edge, num);
         fails++;
         return;
      end
      r = edge_queue.pop_front();
      if (new_edge !== r.new_edge) begin
         $display("%0t: new_edge exp %h got %h", $time, r.new_edge, new_edge);
         fails++;
      end
      if (num !== r.edge_number) begin
         $display("%0t: edge_number exp %0d got %0d", $time, r.edge_number, num);
         fails++;
      end
      if (last !== r.last_edge) begin
         $display("%0t: last_edge exp %b got %b", $time, r.last_edge, last);
         fails++;
      end
      if (st !== r.status) begin
         $display("%0t: status exp %0d got %0d", $time, r.status, st);
         fails++;
      end
   endfunction

   function int pending();
      return edge_queue.size();
   endfunction
endclass

module tb_top;
   localparam int StallLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_NONE;
   logic [9:0]  req_bin_index = '0;
   logic [31:0] req_bin_weight = '0;
   logic [31:0] req_old_edge = '0;
   logic [31:0] req_target_weight = '0;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;
   logic        rsp_valid;
   logic [31:0] rsp_new_edge;
   logic [9:0]  rsp_edge_number;
   logic        rsp_last_edge;
   logic [1:0]  rsp_status;

   rebin_scoreboard sb = new();
   int          idle_cycles = 0;
   int          items_sent = 0;
   int          burst_left = 0;

   always #5 clock = ~clock;

   adaptive_grid_rebin i_dut (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_bin_index, .req_bin_weight, .req_old_edge, .req_target_weight,
      .csr_wr_en, .csr_wr_data,
      .rsp_valid, .rsp_new_edge, .rsp_edge_number, .rsp_last_edge, .rsp_status
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_edge(rsp_new_edge, rsp_edge_number, rsp_last_edge, rsp_status);
   end

   // watchdog on cycles where neither side moves an item
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(opcode_type op, logic [9:0] idx, logic [31:0] wt,
                            logic [31:0] old_e, logic [31:0] tgt);
      start             <= 1'b1;
      req_opcode        <= op;
      req_bin_index     <= idx;
      req_bin_weight    <= wt;
      req_old_edge      <= old_e;
      req_target_weight <= tgt;
      do @(posedge clock); while (busy);
      sb.accept_item(op, idx, wt, old_e, tgt);
      items_sent++;
      // bursts of back-to-back items, then usually a random gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bins(logic [9:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.write_bins(value);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return $urandom;
         default: return $urandom_range(0, 'h30000);
      endcase
   endfunction

   function automatic logic [31:0] rand_edge(int unsigned k);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, EdgeOne);
      return 32'((EdgeOne / MaxBins) * k + $urandom_range(0, 'hFFFF));
   endfunction

   // share of the weight per new bin, with occasional off-balance targets
   function automatic logic [31:0] pick_target();
      logic [63:0] total;
      int unsigned nd;
      nd    = sb.grid_size();
      total = '0;
      for (int k = 0; k < nd; k++) total += sb.weight_mem[k];
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         3:       return 32'(total / nd + $urandom_range(1, 'h8000));
         default: return 32'(total / nd);
      endcase
   endfunction

   initial begin
      int unsigned nd;
      logic [9:0]  setting;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry written before any walk can reach it
      for (int k = 1; k <= MaxBins; k++)
         send_item(OP_LOAD, 10'(k), rand_weight(), 32'((EdgeOne / MaxBins) * k), '0);

      // directed corners
      send_item(OP_NONE, 10'd5, '1, '1, '1);
      send_item(OP_LOAD, 10'd0, '1, '1, '0);
      send_item(OP_LOAD, 10'd513, '1, '1, '0);
      send_item(OP_LOAD, 10'd1023, '1, '1, '0);
      send_item(OP_LOAD, 10'd1, 32'hFFFF_FFFF, 32'd0, '0);
      send_item(OP_LOAD, 10'd2, 32'd0, EdgeOne, '0);
      send_item(OP_LOAD, 10'd3, 32'h0001_0000, 32'h1000_0000, '0);
      send_item(OP_LOAD, 10'd512, 32'h0001_0000, EdgeOne, '0);
      send_item(OP_START, '0, '0, '0, 32'd0);
      send_item(OP_EMIT, '0, '0, '0, '0);
      send_item(OP_START, '0, '0, '0, 32'h0001_0000);
      repeat (3) send_item(OP_EMIT, '0, '0, '0, '0);
      send_item(OP_START, '0, '0, '0, 32'hFFFF_FFFF);
      repeat (3) send_item(OP_EMIT, '0, '0, '0, '0);
      write_bins(10'd2);
      send_item(OP_START, '0, '0, '0, 32'h0000_8000);
      repeat (4) send_item(OP_EMIT, '0, '0, '0, '0);

      while (items_sent < 1800) begin
         case ($urandom_range(0, 11))
            0:       setting = 10'd0;
            1:       setting = 10'd1;
            2:       setting = 10'd512;
            3:       setting = 10'($urandom_range(513, 1023));
            4:       setting = 10'($urandom_range(2, 511));
            default: setting = 10'($urandom_range(2, 16));
         endcase
         write_bins(setting);
         nd = sb.grid_size();
         repeat ($urandom_range(0, 8)) begin
            int unsigned k;
            k = $urandom_range(1, nd);
            if ($urandom_range(0, 9) == 0)
               send_item(OP_LOAD, 10'($urandom), $urandom, $urandom, '0);
            else send_item(OP_LOAD, 10'(k), rand_weight(), rand_edge(k), $urandom);
         end
         send_item(OP_START, 10'($urandom), $urandom, $urandom, pick_target());
         for (int e = 0; e < nd + $urandom_range(0, 2); e++) begin
            case ($urandom_range(0, 39))
               0:       send_item(OP_NONE, 10'($urandom), $urandom, $urandom, $urandom);
               1:       send_item(OP_START, 10'($urandom), $urandom, $urandom,
                                  pick_target());
               2:       send_item(OP_LOAD, 10'($urandom_range(1, nd)), rand_weight(),
                                  rand_edge($urandom_range(1, nd)), $urandom);
               default: send_item(OP_EMIT, 10'($urandom), $urandom, $urandom, $urandom);
            endcase
         end
      end

      settle();
      repeat (50) @(posedge clock);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
